// File: rtl/vgaattr_pkg.sv
`timescale 1ns / 1ps

package vgaattr_pkg;

    localparam int PaletteEntries = 16;
    localparam int IndexW         = 5;
    localparam int ColorW         = 6;
    localparam int ByteW          = 8;

    typedef enum logic [1:0] {
        OP_READ_INDEX = 2'd0,
        OP_READ_DATA  = 2'd1,
        OP_WRITE      = 2'd2
    } t_opcode;

    localparam logic [IndexW-1:0] IDX_MODE      = 5'h10;
    localparam logic [IndexW-1:0] IDX_OVERSCAN  = 5'h11;
    localparam logic [IndexW-1:0] IDX_PLANE_EN  = 5'h12;
    localparam logic [IndexW-1:0] IDX_PEL_PAN   = 5'h13;
    localparam logic [IndexW-1:0] IDX_COLOR_SEL = 5'h14;
    localparam logic [IndexW-1:0] IDX_LAST      = IDX_COLOR_SEL;

    localparam logic [ByteW-1:0] INVALID_BYTE = 8'hFF;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [IndexW-1:0] index;
        logic [ColorW-1:0] wdata;
    } t_pal_req;

endpackage

// File: rtl/vgaattr_in_if.sv
`timescale 1ns / 1ps

interface vgaattr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] write_byte;

    modport source(output valid, output opcode, output write_byte, input ready);
    modport sink(input valid, input opcode, input write_byte, output ready);
endinterface

// File: rtl/vgaattr_out_if.sv
`timescale 1ns / 1ps

interface vgaattr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;

    modport source(output valid, output read_byte, input ready);
    modport sink(input valid, input read_byte, output ready);
endinterface

// File: rtl/vgaattr_pal.sv
`timescale 1ns / 1ps

module vgaattr_pal #(
    parameter int P_ENTRIES = vgaattr_pkg::PaletteEntries
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vgaattr_pkg::t_pal_req               i_req,
    output logic [vgaattr_pkg::ColorW-1:0]      o_rd_data
);

    localparam int AW = $clog2(P_ENTRIES);

    logic [vgaattr_pkg::ColorW-1:0] r_mem [P_ENTRIES];
    logic [P_ENTRIES-1:0]           r_vld;
    logic [vgaattr_pkg::ColorW-1:0] r_rd_data;
    logic                           r_rd_vld;
    logic [AW-1:0]                  w_addr;

    assign w_addr = i_req.index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[w_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[w_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[w_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: rtl/vga_attribute_register_file_unit.sv
`timescale 1ns / 1ps

// Attribute controller register file behind an address/data flip-flop. Every write word
// toggles between an index phase and a data phase; reads return the index or the selected
// register, 0xFF for an index above 0x14. One word is taken per cycle unless input stalls.
// A read is held pending after acceptance, palette data registered at the RAM's read port,
// and input stalls only while that result cannot move into a full, unread output register.
// The palette clears at reset through per-entry valid bits, so no clearing pass is needed.
module vga_attribute_register_file_unit #(
    parameter int PALETTE_ENTRIES = vgaattr_pkg::PaletteEntries
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vgaattr_in_if.sink    i_in,
    vgaattr_out_if.source o_out
);

    logic                              r_data_phase;
    logic [vgaattr_pkg::IndexW-1:0]    r_reg_index;
    logic                              r_index_invalid;
    logic                              r_pal_from_video;
    logic [7:0]                        r_mode;
    logic [7:0]                        r_border;
    logic [3:0]                        r_plane_en;
    logic [1:0]                        r_status_mux;
    logic [2:0]                        r_pan;
    logic [3:0]                        r_color_sel;
    logic                              r_busy;
    logic                              r_busy_data;
    logic                              r_out_valid;
    logic [7:0]                        r_out_byte;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_done;
    logic                              w_wr;
    logic                              w_rd;
    logic                              w_reg_wr;
    logic                              w_is_pal;
    logic [7:0]                        w_result;
    logic [vgaattr_pkg::ColorW-1:0]    w_pal_rd;
    vgaattr_pkg::t_pal_req             w_pal_req;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_done     = r_busy && w_out_free;
    assign i_in.ready = !r_busy || w_out_free;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_wr = w_in_acc && (i_in.opcode == vgaattr_pkg::OP_WRITE);
    assign w_rd = w_in_acc && (i_in.opcode inside {vgaattr_pkg::OP_READ_INDEX,
                                                   vgaattr_pkg::OP_READ_DATA});

    assign w_is_pal = int'(r_reg_index) < PALETTE_ENTRIES;
    assign w_reg_wr = w_wr && r_data_phase && !r_index_invalid;

    assign w_pal_req.wr_en = w_reg_wr && w_is_pal && !r_pal_from_video;
    assign w_pal_req.rd_en = w_in_acc && (i_in.opcode == vgaattr_pkg::OP_READ_DATA);
    assign w_pal_req.index = r_reg_index;
    assign w_pal_req.wdata = i_in.write_byte[vgaattr_pkg::ColorW-1:0];

    vgaattr_pal #(
        .P_ENTRIES(PALETTE_ENTRIES)
    ) u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_pal_req),
        .o_rd_data(w_pal_rd)
    );

    always_comb begin
        w_result = vgaattr_pkg::INVALID_BYTE;
        if (r_index_invalid) begin
            w_result = vgaattr_pkg::INVALID_BYTE;
        end else if (!r_busy_data) begin
            w_result = {3'b000, r_reg_index};
        end else if (w_is_pal) begin
            w_result = {2'b00, w_pal_rd};
        end else begin
            case (r_reg_index)
                vgaattr_pkg::IDX_MODE:      w_result = r_mode;
                vgaattr_pkg::IDX_OVERSCAN:  w_result = r_border;
                vgaattr_pkg::IDX_PLANE_EN:  w_result = {4'h0, r_plane_en};
                vgaattr_pkg::IDX_PEL_PAN:   w_result = {5'h00, r_pan};
                vgaattr_pkg::IDX_COLOR_SEL: w_result = {4'h0, r_color_sel};
                default:                    w_result = vgaattr_pkg::INVALID_BYTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_phase     <= 1'b0;
            r_reg_index      <= '0;
            r_index_invalid  <= 1'b0;
            r_pal_from_video <= 1'b0;
            r_mode           <= '0;
            r_border         <= '0;
            r_plane_en       <= '0;
            r_status_mux     <= '0;
            r_pan            <= '0;
            r_color_sel      <= '0;
        end else if (w_wr) begin
            r_data_phase <= !r_data_phase;
            if (!r_data_phase) begin
                r_reg_index      <= i_in.write_byte[vgaattr_pkg::IndexW-1:0];
                r_index_invalid  <= i_in.write_byte[vgaattr_pkg::IndexW-1:0]
                                    > vgaattr_pkg::IDX_LAST;
                r_pal_from_video <= i_in.write_byte[5];
            end else if (w_reg_wr) begin
                case (r_reg_index)
                    vgaattr_pkg::IDX_MODE: begin
                        r_mode <= {i_in.write_byte[7:5], 1'b0, i_in.write_byte[3:0]};
                    end
                    vgaattr_pkg::IDX_OVERSCAN: begin
                        r_border <= i_in.write_byte;
                    end
                    vgaattr_pkg::IDX_PLANE_EN: begin
                        r_plane_en   <= i_in.write_byte[3:0];
                        r_status_mux <= i_in.write_byte[5:4];
                    end
                    vgaattr_pkg::IDX_PEL_PAN: begin
                        r_pan <= i_in.write_byte[3] ? 3'd0 : i_in.write_byte[2:0];
                    end
                    vgaattr_pkg::IDX_COLOR_SEL: begin
                        r_color_sel <= i_in.write_byte[3:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_busy_data <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rd) begin
                r_busy      <= 1'b1;
                r_busy_data <= i_in.opcode == vgaattr_pkg::OP_READ_DATA;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_byte <= w_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_byte = r_out_byte;

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !w_out_free |=> r_busy)
        else $error("pending read dropped while output is full");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd |=> r_busy)
        else $error("accepted read left no pending result");

    a_phase_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && !r_data_phase |=> r_data_phase)
        else $error("index write did not advance to data phase");

    a_invalid_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index_invalid |-> r_reg_index > vgaattr_pkg::IDX_LAST)
        else $error("index marked invalid while in range");

    a_status_mux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reg_wr && r_reg_index == vgaattr_pkg::IDX_PLANE_EN
        |=> r_status_mux == $past(i_in.write_byte[5:4]))
        else $error("status mux not taken from plane enable word");

endmodule

// File: bench/tb_vga_attribute_register_file_unit.sv
`timescale 1ns / 1ps

module tb_vga_attribute_register_file_unit;

    localparam logic [1:0] OpUnused    = 2'd3;
    localparam int         IdleHeavy   = 87;
    localparam int         IdleMixed   = 35;
    localparam int         HoldCycles  = 300;
    localparam int         DrainCycles = 20;
    localparam int         CycleLimit  = 400000;
    localparam int         NumDirected = 28;

    typedef struct packed {
        logic [1:0]                    op;
        logic [vgaattr_pkg::ByteW-1:0] wbyte;
        logic                          known;
        logic [vgaattr_pkg::ByteW-1:0] want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vgaattr_in_if  in_bus();
    vgaattr_out_if out_bus();

    vga_attribute_register_file_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the register file
    logic                           at_data_phase = 1'b0;
    logic [vgaattr_pkg::IndexW-1:0] cur_index     = '0;
    logic                           cur_invalid   = 1'b0;
    logic                           video_owns_pal = 1'b0;
    logic [vgaattr_pkg::ColorW-1:0] pal_mem [vgaattr_pkg::PaletteEntries] = '{default: '0};
    logic [7:0]        mode_q     = '0;
    logic [7:0]        overscan_q = '0;
    logic [3:0]        plane_q    = '0;
    logic [1:0]        mux_q      = '0;
    logic [2:0]        pan_q      = '0;
    logic [3:0]        colsel_q   = '0;

    logic [vgaattr_pkg::ByteW-1:0] read_queue [$];
    logic [vgaattr_pkg::ByteW-1:0] want_byte;
    int               mismatches   = 0;
    int               reads_seen   = 0;
    int               words_sent   = 0;
    int               cycle_count  = 0;
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    logic             hold_req;
    int               hold_cnt = 0;

    t_dir_row dir_table [NumDirected] = '{
        '{vgaattr_pkg::OP_READ_INDEX, 8'h00, 1'b1, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'hFF, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_INDEX, 8'h00, 1'b1, vgaattr_pkg::INVALID_BYTE},
        '{vgaattr_pkg::OP_READ_DATA,  8'hFF, 1'b1, vgaattr_pkg::INVALID_BYTE},
        '{vgaattr_pkg::OP_WRITE,      8'h00, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'h0F, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'hFF, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h3F},
        '{vgaattr_pkg::OP_WRITE,      8'h2F, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'h00, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h3F},
        '{vgaattr_pkg::OP_WRITE,      8'h10, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'hFF, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'hEF},
        '{vgaattr_pkg::OP_WRITE,      8'hD1, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'h80, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h80},
        '{vgaattr_pkg::OP_WRITE,      8'h12, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'hFF, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h0F},
        '{vgaattr_pkg::OP_WRITE,      8'h13, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'h08, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'h14, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_WRITE,      8'hFF, 1'b0, 8'h00},
        '{vgaattr_pkg::OP_READ_DATA,  8'h00, 1'b1, 8'h0F},
        '{OpUnused,                   8'hFF, 1'b0, 8'h00}
    };

    function automatic logic [vgaattr_pkg::ByteW-1:0] selected_reg();
        if (cur_invalid) return vgaattr_pkg::INVALID_BYTE;
        if (cur_index < vgaattr_pkg::PaletteEntries) return {2'b00, pal_mem[cur_index[3:0]]};
        case (cur_index)
            vgaattr_pkg::IDX_MODE:      return mode_q;
            vgaattr_pkg::IDX_OVERSCAN:  return overscan_q;
            vgaattr_pkg::IDX_PLANE_EN:  return {4'b0000, plane_q};
            vgaattr_pkg::IDX_PEL_PAN:   return {5'b00000, pan_q};
            vgaattr_pkg::IDX_COLOR_SEL: return {4'b0000, colsel_q};
            default:                    return vgaattr_pkg::INVALID_BYTE;
        endcase
    endfunction

    function automatic void update_selected(input logic [vgaattr_pkg::ByteW-1:0] b);
        if (cur_invalid) return;
        if (cur_index < vgaattr_pkg::PaletteEntries) begin
            if (!video_owns_pal) pal_mem[cur_index[3:0]] = b[5:0];
            return;
        end
        case (cur_index)
            vgaattr_pkg::IDX_MODE:      mode_q = {b[7:5], 1'b0, b[3:0]};
            vgaattr_pkg::IDX_OVERSCAN:  overscan_q = b;
            vgaattr_pkg::IDX_PLANE_EN: begin
                plane_q = b[3:0];
                mux_q   = b[5:4];
            end
            vgaattr_pkg::IDX_PEL_PAN:   pan_q = b[3] ? 3'd0 : b[2:0];
            vgaattr_pkg::IDX_COLOR_SEL: colsel_q = b[3:0];
            default: ;
        endcase
    endfunction

    // returns 1 when the access produces a read byte
    function automatic logic attr_access(input logic [1:0] op,
                                         input logic [vgaattr_pkg::ByteW-1:0] b,
                                         output logic [vgaattr_pkg::ByteW-1:0] rdata);
        rdata = '0;
        case (op)
            vgaattr_pkg::OP_READ_INDEX: begin
                rdata = cur_invalid ? vgaattr_pkg::INVALID_BYTE : {3'b000, cur_index};
                return 1'b1;
            end
            vgaattr_pkg::OP_READ_DATA: begin
                rdata = selected_reg();
                return 1'b1;
            end
            vgaattr_pkg::OP_WRITE: begin
                if (!at_data_phase) begin
                    cur_index      = b[4:0];
                    cur_invalid    = b[4:0] > vgaattr_pkg::IDX_LAST;
                    video_owns_pal = b[5];
                    at_data_phase  = 1'b1;
                end else begin
                    update_selected(b);
                    at_data_phase = 1'b0;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_word(input logic [1:0] op, input logic [vgaattr_pkg::ByteW-1:0] b,
                             input logic known, input logic [vgaattr_pkg::ByteW-1:0] want);
        logic [vgaattr_pkg::ByteW-1:0] rdata;
        logic                          has_read;
        while ($urandom_range(99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.opcode     <= op;
        in_bus.write_byte <= b;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        has_read = attr_access(op, b, rdata);
        if (has_read) read_queue.push_back(known ? want : rdata);
        if (op != OpUnused) words_sent++;
    endtask

    task automatic issue(input logic [1:0] op, input logic [vgaattr_pkg::ByteW-1:0] b);
        send_word(op, b, 1'b0, 8'h00);
    endtask

    // one index/data sequence with random content, or a short run of noise
    task automatic random_burst();
        logic [vgaattr_pkg::IndexW-1:0] idx;
        logic [vgaattr_pkg::ByteW-1:0]  addr_byte;
        int                             n;
        if ($urandom_range(9) < 8) begin
            if (at_data_phase) issue(vgaattr_pkg::OP_WRITE, 8'($urandom));
            idx = ($urandom_range(99) < 85) ? 5'($urandom_range(20))
                                            : 5'($urandom_range(31, 21));
            addr_byte = {2'($urandom), ($urandom_range(99) < 25), idx};
            issue(vgaattr_pkg::OP_WRITE, addr_byte);
            if ($urandom_range(1)) issue(vgaattr_pkg::OP_READ_INDEX, 8'($urandom));
            if ($urandom_range(1)) issue(vgaattr_pkg::OP_READ_DATA, 8'($urandom));
            if ($urandom_range(9) != 0) issue(vgaattr_pkg::OP_WRITE, 8'($urandom));
            if ($urandom_range(9) < 8) issue(vgaattr_pkg::OP_READ_DATA, 8'($urandom));
            if ($urandom_range(9) < 3) issue(vgaattr_pkg::OP_READ_INDEX, 8'($urandom));
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) issue(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    task automatic random_phase(input int src_pct, input int snk_pct, input int count);
        int stop_at;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = words_sent + count;
        while (words_sent < stop_at) random_burst();
    endtask

    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= HoldCycles;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            reads_seen++;
            if (read_queue.size() == 0) begin
                report_mismatch($sformatf("read byte %02h with nothing outstanding",
                                          out_bus.read_byte));
            end else begin
                want_byte = read_queue.pop_front();
                if (out_bus.read_byte !== want_byte) begin
                    report_mismatch($sformatf("read_byte %02h, want %02h",
                                              out_bus.read_byte, want_byte));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d reads outstanding", cycle_count,
                     read_queue.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        hold_req          = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.opcode     = vgaattr_pkg::OP_READ_INDEX;
        in_bus.write_byte = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NumDirected; i++) begin
            send_word(dir_table[i].op, dir_table[i].wbyte, dir_table[i].known,
                      dir_table[i].want);
        end

        random_phase(0, 0, 350);
        random_phase(IdleHeavy, 0, 300);
        random_phase(0, IdleHeavy, 300);
        random_phase(IdleMixed, IdleMixed, 300);

        // hold the output off while reads keep coming
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        in_bus.valid <= 1'b0;
        hold_req     <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (40) issue(vgaattr_pkg::OP_READ_DATA, 8'($urandom));

        random_phase(0, 0, 300);

        in_bus.valid <= 1'b0;
        while (read_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d bus words and %0d read bytes across four idle mixes",
                 words_sent, reads_seen);
        $display("and one long output hold-off; %0d errors counted", mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/vgaattr_pkg.sv
rtl/vgaattr_in_if.sv
rtl/vgaattr_out_if.sv
rtl/vgaattr_pal.sv
rtl/vga_attribute_register_file_unit.sv
bench/tb_vga_attribute_register_file_unit.sv
